// File: hw/rtl/cssc_pkg.sv
// Shared types, constants and elaboration-time functions for the CORDIC sine/cosine block.
// Used by every module under hw/rtl; depends on nothing else.

package cssc_pkg;

   // Field and datapath widths.
   localparam int AngleWidth   = 32;   // Q5.26 angle
   localparam int ResultWidth  = 18;   // Q1.16 cosine and sine
   localparam int RspDataWidth = 40;   // two results packed, padded to whole bytes
   localparam int XyWidth      = 33;   // x, y and z in Q30 with headroom
   localparam int ResidWidth   = 27;   // reduced angle in Q26, never above pi/2
   localparam int QuoWidth     = 5;    // quotient of |angle| / (pi/2) is at most 20
   localparam int ProdWidth    = 64;   // gain product, Q60

   // pi/2 in Q26, rounded to nearest, and one in Q30.
   localparam int HalfPiQ26 = 105414357;
   localparam logic signed [XyWidth-1:0] OneQ30 = XyWidth'(1) << 30;

   // Saturation limit of the results.
   localparam logic signed [ResultWidth-1:0] OutMax = ResultWidth'(65536);

   // Quadrant codes.
   localparam logic [1:0] QuadFirst  = 2'd0;
   localparam logic [1:0] QuadSecond = 2'd1;
   localparam logic [1:0] QuadThird  = 2'd2;
   localparam logic [1:0] QuadFourth = 2'd3;

   // One stage of the quadrant reduction.
   typedef struct packed {
      logic                  valid;
      logic                  neg;
      logic [AngleWidth-1:0] rem;
      logic [QuoWidth-1:0]   quo;
   } reduce_stage_type;

   // One stage of the rotation chain.
   typedef struct packed {
      logic                      valid;
      logic [1:0]                quad;
      logic [ResidWidth-1:0]     resid;
      logic signed [XyWidth-1:0] x;
      logic signed [XyWidth-1:0] y;
      logic signed [XyWidth-1:0] z;
   } rotate_stage_type;

   // A finished result; cosine sits in the low bits.
   typedef struct packed {
      logic signed [ResultWidth-1:0] sine;
      logic signed [ResultWidth-1:0] cosine;
   } result_type;

   // atan(2^-i) in Q30, rounded to nearest.
   function automatic logic signed [XyWidth-1:0] atan_q30(input int i);
      logic signed [XyWidth-1:0] v;
      case (i)
         0:  v = 33'sd843314857;
         1:  v = 33'sd497837829;
         2:  v = 33'sd263043837;
         3:  v = 33'sd133525159;
         4:  v = 33'sd67021687;
         5:  v = 33'sd33543516;
         6:  v = 33'sd16775851;
         7:  v = 33'sd8388437;
         8:  v = 33'sd4194283;
         9:  v = 33'sd2097149;
         10: v = 33'sd1048576;
         11: v = 33'sd524288;
         12: v = 33'sd262144;
         13: v = 33'sd131072;
         14: v = 33'sd65536;
         15: v = 33'sd32768;
         16: v = 33'sd16384;
         17: v = 33'sd8192;
         18: v = 33'sd4096;
         19: v = 33'sd2048;
         20: v = 33'sd1024;
         21: v = 33'sd512;
         22: v = 33'sd256;
         23: v = 33'sd128;
         default: v = '0;
      endcase
      return v;
   endfunction

   // CORDIC gain in Q30: product of 1/sqrt(1 + 4^-k) over the iterations.
   // The product of (1 + 4^-k) is kept in Q61, then an exact integer
   // inverse square root is found bit by bit. Evaluated at elaboration only.
   function automatic logic [30:0] gain_q30(input int iters);
      logic [63:0]  p;
      logic [63:0]  h;
      logic [63:0]  t;
      logic [127:0] pr;
      p = 64'd1 << 61;
      h = '0;
      for (int k = 0; k < iters; k++) begin
         if (2 * k < 62) begin
            p = p + (p >> (2 * k));
         end
      end
      for (int b = 30; b >= 0; b--) begin
         t  = h | (64'd1 << b);
         pr = {64'd0, t * t} * {64'd0, p};
         if (pr <= (128'd1 << 123)) begin
            h = t;
         end
      end
      return 31'((h + 64'd1) >> 1);
   endfunction

endpackage

// File: hw/rtl/cssc_reduce_cell.sv
// One compare-and-subtract cell of the quadrant reduction chain.
// Depends on cssc_pkg for the stage type and the pi/2 constant.

module cssc_reduce_cell import cssc_pkg::*; #(
   parameter int SHIFT = 0
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  reduce_stage_type stage_in,
   output reduce_stage_type stage_out
);

   // pi/2 weighted by this cell's quotient bit.
   localparam logic [AngleWidth-1:0] Divisor = AngleWidth'(HalfPiQ26 * (2 ** SHIFT));

   reduce_stage_type stage_in_q;
   reduce_stage_type stage_ff;

   // Take the divisor off the remainder when it fits and set the quotient bit.
   always_comb begin
      stage_in_q = stage_in;
      if (stage_in.rem >= Divisor) begin
         stage_in_q.rem       = stage_in.rem - Divisor;
         stage_in_q.quo[SHIFT] = 1'b1;
      end
   end

   // Only the valid bit needs a reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_ff <= stage_in_q;
      end
   end

   assign stage_out = stage_ff;

endmodule

// File: hw/rtl/cssc_rotate_cell.sv
// One micro-rotation cell of the CORDIC chain, with its own stage register.
// Depends on cssc_pkg for the stage type and the arctangent table.

module cssc_rotate_cell import cssc_pkg::*; #(
   parameter int SHIFT = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  rotate_stage_type stage_in,
   output rotate_stage_type stage_out
);

   localparam logic signed [XyWidth-1:0] AtanStep = atan_q30(SHIFT);

   logic                      dir_up;
   logic signed [XyWidth-1:0] x_shift;
   logic signed [XyWidth-1:0] y_shift;
   rotate_stage_type          stage_in_r;
   rotate_stage_type          stage_ff;

   // Rotate towards the residual: compare it, in Q30, against the angle so far.
   assign dir_up  = $signed({2'b00, stage_in.resid, 4'b0000}) >= $signed(stage_in.z);
   assign x_shift = $signed(stage_in.x) >>> SHIFT;
   assign y_shift = $signed(stage_in.y) >>> SHIFT;

   always_comb begin
      stage_in_r = stage_in;
      if (dir_up) begin
         stage_in_r.x = $signed(stage_in.x) - y_shift;
         stage_in_r.y = $signed(stage_in.y) + x_shift;
         stage_in_r.z = $signed(stage_in.z) + AtanStep;
      end else begin
         stage_in_r.x = $signed(stage_in.x) + y_shift;
         stage_in_r.y = $signed(stage_in.y) - x_shift;
         stage_in_r.z = $signed(stage_in.z) - AtanStep;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_ff <= stage_in_r;
      end
   end

   assign stage_out = stage_ff;

endmodule

// File: hw/rtl/cssc_scale_out.sv
// Gain scaling, rounding, saturation, quadrant mapping and the output skid buffer.
// Depends on cssc_pkg for the stage and result types and the gain function.

module cssc_scale_out import cssc_pkg::*; #(
   parameter int ITERATIONS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  rotate_stage_type        stage_in,
   output logic                    advance,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [RspDataWidth-1:0] rsp_tdata
);

   localparam logic [30:0] Gain = gain_q30(ITERATIONS);

   logic                        mul_valid_ff;
   logic [1:0]                  mul_quad_ff;
   logic signed [ProdWidth-1:0] prod_x_ff;
   logic signed [ProdWidth-1:0] prod_y_ff;
   logic signed [ResultWidth-1:0] cos_base;
   logic signed [ResultWidth-1:0] sin_base;
   result_type                  pipe_res;
   logic                        pipe_fire;
   logic                        out_valid_ff;
   result_type                  out_data_ff;
   logic                        skid_valid_ff;
   result_type                  skid_data_ff;

   // Round half up from Q60 to Q16 and clamp to plus or minus one.
   function automatic logic signed [ResultWidth-1:0] to_q16(input logic signed [ProdWidth-1:0] p);
      logic signed [ProdWidth-1:0] s;
      logic signed [19:0]          r;
      s = p + (ProdWidth'(1) << 43);
      r = s[ProdWidth-1:44];
      if (r > 20'sd65536) begin
         return OutMax;
      end else if (r < -20'sd65536) begin
         return -OutMax;
      end
      return r[ResultWidth-1:0];
   endfunction

   // The whole pipeline moves unless the skid register is holding a result.
   assign advance = !skid_valid_ff;

   // Multiply by the gain; registered before any further arithmetic.
   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
      end else if (advance) begin
         mul_valid_ff <= stage_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mul_quad_ff <= stage_in.quad;
         prod_x_ff   <= $signed(stage_in.x) * $signed({1'b0, Gain});
         prod_y_ff   <= $signed(stage_in.y) * $signed({1'b0, Gain});
      end
   end

   assign cos_base = to_q16(prod_x_ff);
   assign sin_base = to_q16(prod_y_ff);

   // Swap or negate to move the first-quadrant result to the right quadrant.
   always_comb begin
      pipe_res.cosine = cos_base;
      pipe_res.sine   = sin_base;
      case (mul_quad_ff)
         QuadSecond: begin
            pipe_res.cosine = -sin_base;
            pipe_res.sine   = cos_base;
         end
         QuadThird: begin
            pipe_res.cosine = -cos_base;
            pipe_res.sine   = -sin_base;
         end
         QuadFourth: begin
            pipe_res.cosine = sin_base;
            pipe_res.sine   = -cos_base;
         end
         default: begin
         end
      endcase
   end

   assign pipe_fire = mul_valid_ff && advance;

   // Output register with a skid register behind it.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_tready) begin
         out_valid_ff  <= skid_valid_ff || pipe_fire;
         skid_valid_ff <= 1'b0;
      end else if (pipe_fire) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || rsp_tready) begin
         out_data_ff <= skid_valid_ff ? skid_data_ff : pipe_res;
      end else if (pipe_fire) begin
         skid_data_ff <= pipe_res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RspDataWidth - 2 * ResultWidth){1'b0}}, out_data_ff};

endmodule

// File: hw/rtl/cordic_sine_cosine.sv
// Top level of the CORDIC sine/cosine generator: quadrant reduction chain,
// rotation chain and output stage. Depends on cssc_pkg and the cssc_* cells.
//
//   Channel | Direction | Handshake              | Payload
//   req     | in        | req_tvalid/req_tready  | req_tdata[31:0] angle, Q5.26
//   rsp     | out       | rsp_tvalid/rsp_tready  | rsp_tdata cosine, sine in Q1.16
//
// One request is accepted every clock while the result side keeps up.
// A request passes the input register, five reduction cells, the seed register,
// ITERATIONS - 1 rotation cells, the gain multiply and the output register.
// Reset is synchronous and clears the valid bits only; no clearing pass follows.
// A stalled result parks in a skid register; the whole chain then holds and
// req_tready, taken from that register, drops until the result is taken.

module cordic_sine_cosine import cssc_pkg::*; #(
   parameter int ITERATIONS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [AngleWidth-1:0]   req_tdata,   // [31:0] angle
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [RspDataWidth-1:0] rsp_tdata    // [17:0] cosine, [35:18] sine, [39:36] zero
);

   localparam int ReduceSteps = QuoWidth;

   logic             advance;
   reduce_stage_type in_in;
   reduce_stage_type in_ff;
   reduce_stage_type red [0:ReduceSteps];
   rotate_stage_type seed_in;
   rotate_stage_type seed_ff;
   rotate_stage_type rot [0:ITERATIONS-1];

   assign req_tready = advance;

   // Input register: keep the sign and take the magnitude of the angle.
   always_comb begin
      in_in.valid = req_tvalid;
      in_in.neg   = req_tdata[AngleWidth-1];
      in_in.rem   = req_tdata[AngleWidth-1] ? (~req_tdata + AngleWidth'(1)) : req_tdata;
      in_in.quo   = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_ff.valid <= 1'b0;
      end else if (advance) begin
         in_ff <= in_in;
      end
   end

   assign red[0] = in_ff;

   // Restoring division by pi/2, one quotient bit per cell, top bit first.
   for (genvar j = 0; j < ReduceSteps; j++) begin : g_reduce
      cssc_reduce_cell #(
         .SHIFT (ReduceSteps - 1 - j)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .stage_in  (red[j]),
         .stage_out (red[j+1])
      );
   end

   // Seed register: signed residual folded into [0, pi/2] and the start vector.
   always_comb begin
      seed_in.valid = red[ReduceSteps].valid;
      if (red[ReduceSteps].neg) begin
         seed_in.resid = ResidWidth'(AngleWidth'(HalfPiQ26) - red[ReduceSteps].rem);
         seed_in.quad  = ~red[ReduceSteps].quo[1:0];
      end else begin
         seed_in.resid = red[ReduceSteps].rem[ResidWidth-1:0];
         seed_in.quad  = red[ReduceSteps].quo[1:0];
      end
      seed_in.x = OneQ30;
      seed_in.y = OneQ30;
      seed_in.z = atan_q30(0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff.valid <= 1'b0;
      end else if (advance) begin
         seed_ff <= seed_in;
      end
   end

   assign rot[0] = seed_ff;

   // Rotation chain, one micro-rotation per cell.
   for (genvar i = 1; i < ITERATIONS; i++) begin : g_rotate
      cssc_rotate_cell #(
         .SHIFT (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .stage_in  (rot[i-1]),
         .stage_out (rot[i])
      );
   end

   // Scaling, quadrant mapping and the result channel.
   cssc_scale_out #(
      .ITERATIONS (ITERATIONS)
   ) u_scale_out (
      .clock      (clock),
      .reset      (reset),
      .stage_in   (rot[ITERATIONS-1]),
      .advance    (advance),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// File: hw/rtl/cssc_checker.sv
// Port-level checks for the CORDIC sine/cosine generator, bound to the top level.
// Depends on cssc_pkg for widths and on cordic_sine_cosine for the bind.

module cssc_checker import cssc_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_tvalid,
   input logic                    req_tready,
   input logic [AngleWidth-1:0]   req_tdata,
   input logic                    rsp_tvalid,
   input logic                    rsp_tready,
   input logic [RspDataWidth-1:0] rsp_tdata
);

   // A result that is not taken stays, unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed or vanished while stalled");

   // Reset leaves no result pending.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result pending after reset");

   // Requests are refused only while a result waits to be taken.
   a_ready_low: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !$past(rsp_tready))
      else $error("request refused with no stalled result");

   // Both results stay within plus or minus one and the padding is zero.
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RspDataWidth-1:2*ResultWidth] == '0
         && $signed(rsp_tdata[ResultWidth-1:0]) <= 18'sd65536
         && $signed(rsp_tdata[ResultWidth-1:0]) >= -18'sd65536
         && $signed(rsp_tdata[2*ResultWidth-1:ResultWidth]) <= 18'sd65536
         && $signed(rsp_tdata[2*ResultWidth-1:ResultWidth]) >= -18'sd65536)
      else $error("result out of range");

endmodule

bind cordic_sine_cosine cssc_checker u_cssc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// File: bench/cordic_sine_cosine_checker.sv
// Checker for the CORDIC sine/cosine generator: watches both channels,
// predicts cosine and sine for each accepted request and compares results.
// Depends on cssc_pkg for the field widths, quadrant codes and result layout.

module cordic_sine_cosine_checker import cssc_pkg::*; #(
   parameter int ITERATIONS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   input  logic                    req_tready,
   input  logic [AngleWidth-1:0]   req_tdata,   // [31:0] angle
   input  logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  logic [RspDataWidth-1:0] rsp_tdata,   // [17:0] cosine, [35:18] sine, [39:36] zero
   output int                      fail_count,
   output int                      pending
);

   // Arctangent of 2^-i in Q30, rounded to nearest.
   longint atan_tab [24] = '{
      843314857, 497837829, 263043837, 133525159,
      67021687, 33543516, 16775851, 8388437,
      4194283, 2097149, 1048576, 524288,
      262144, 131072, 65536, 32768,
      16384, 8192, 4096, 2048,
      1024, 512, 256, 128
   };

   longint     cordic_gain;
   result_type trig_due [$];

   // The gain is the inverse square root of the product of (1 + 4^-k), found bit
   // by bit as the largest h in Q31 with h * h * product not above one in Q123.
   initial begin
      logic [63:0]  product;
      logic [63:0]  root;
      logic [63:0]  trial;
      logic [127:0] wide;
      product = 64'd1 << 61;
      for (int k = 0; k < ITERATIONS; k++) begin
         if (2 * k < 62) begin
            product = product + (product >> (2 * k));
         end
      end
      root = '0;
      for (int b = 30; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         wide  = {64'd0, trial * trial} * {64'd0, product};
         if (wide <= (128'd1 << 123)) begin
            root = trial;
         end
      end
      cordic_gain = longint'((root + 64'd1) >> 1);
   end

   // Scales a Q30 coordinate by the gain, rounds half up to Q16 and saturates.
   function automatic longint round_to_q16(input longint v);
      longint r;
      r = (v * cordic_gain + (64'sd1 <<< 43)) >>> 44;
      if (r > longint'(OutMax)) begin
         r = longint'(OutMax);
      end
      if (r < -longint'(OutMax)) begin
         r = -longint'(OutMax);
      end
      return r;
   endfunction

   // Quadrant reduction, rotation from (1,1) and the per-quadrant swap.
   function automatic result_type sine_cosine_of(input logic signed [AngleWidth-1:0] angle);
      longint     a;
      longint     quo;
      longint     resid;
      longint     x;
      longint     y;
      longint     z;
      longint     xs;
      longint     ys;
      longint     c;
      longint     s;
      longint     held;
      int         quad;
      int         i;
      result_type r;
      a     = angle;
      quo   = a / HalfPiQ26;
      resid = a - quo * HalfPiQ26;
      quad  = int'(quo % 4);
      if (a < 0) begin
         quad  = quad + 3;
         resid = resid + HalfPiQ26;
      end
      x = OneQ30;
      y = OneQ30;
      z = atan_tab[0];
      for (i = 1; i < ITERATIONS && i < 24; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (resid * 16 >= z) begin
            x = x - ys;
            y = y + xs;
            z = z + atan_tab[i];
         end else begin
            x = x + ys;
            y = y - xs;
            z = z - atan_tab[i];
         end
      end
      c = round_to_q16(x);
      s = round_to_q16(y);
      case (2'(quad))
         QuadSecond: begin
            held = c;
            c    = -s;
            s    = held;
         end
         QuadThird: begin
            c = -c;
            s = -s;
         end
         QuadFourth: begin
            held = c;
            c    = s;
            s    = -held;
         end
         default: begin
         end
      endcase
      r.cosine = ResultWidth'(c);
      r.sine   = ResultWidth'(s);
      return r;
   endfunction

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   // Predict on each accepted request, compare on each accepted result.
   always @(posedge clock) begin
      result_type want;
      result_type got;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            trig_due.push_back(sine_cosine_of(req_tdata));
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[2*ResultWidth-1:0];
            if (trig_due.size() == 0) begin
               $display("%0t: result with nothing expected, cosine %0d sine %0d",
                        $time, got.cosine, got.sine);
               fail_count++;
            end else begin
               want = trig_due.pop_front();
               if (got.cosine !== want.cosine) begin
                  $display("%0t: cosine expected %0d actual %0d",
                           $time, want.cosine, got.cosine);
                  fail_count++;
               end
               if (got.sine !== want.sine) begin
                  $display("%0t: sine expected %0d actual %0d",
                           $time, want.sine, got.sine);
                  fail_count++;
               end
               if (rsp_tdata[RspDataWidth-1:2*ResultWidth] !== '0) begin
                  $display("%0t: padding expected 0 actual %h", $time,
                           rsp_tdata[RspDataWidth-1:2*ResultWidth]);
                  fail_count++;
               end
            end
         end
         pending = trig_due.size();
      end
   end

endmodule

// File: bench/cordic_sine_cosine_tb.sv
// Top of the CORDIC sine/cosine bench: clock, reset, angle stimulus, result
// back-pressure and the verdict. Depends on cssc_pkg, the block and its checker.

module cordic_sine_cosine_tb import cssc_pkg::*;;

   localparam int Iterations = 16;
   localparam int Latency    = Iterations + 8;
   localparam int PhaseItems = 260;

   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [AngleWidth-1:0]   req_tdata  = '0;   // [31:0] angle
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RspDataWidth-1:0] rsp_tdata;         // [17:0] cosine, [35:18] sine, [39:36] zero

   int fail_count;
   int pending;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   always #5 clock = ~clock;

   cordic_sine_cosine #(
      .ITERATIONS(Iterations)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   cordic_sine_cosine_checker #(
      .ITERATIONS(Iterations)
   ) u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // The result side stalls at random according to the current phase.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Presents one angle after a random gap and holds it until the request is taken.
   task automatic offer_angle(input logic [AngleWidth-1:0] angle);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= angle;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
   endtask

   // Random angles: raw bit patterns, multiples of pi/2 with small offsets,
   // angles within plus or minus 8 rad and angles near the ends of the range.
   function automatic logic [AngleWidth-1:0] pick_angle();
      int     kind;
      longint k;
      kind = $urandom_range(99);
      if (kind < 35) begin
         return $urandom();
      end else if (kind < 65) begin
         k = longint'($urandom_range(40)) - 20;
         return AngleWidth'(k * HalfPiQ26 + longint'($urandom_range(8)) - 4);
      end else if (kind < 85) begin
         return AngleWidth'(longint'($urandom_range(32'h3FFF_FFFF)) - 64'sh2000_0000);
      end else if (kind < 93) begin
         return 32'h7FFF_FFFF - $urandom_range(255);
      end
      return 32'h8000_0000 + $urandom_range(255);
   endfunction

   initial begin
      longint corner_angles [$];
      corner_angles = '{0, 1, -1, 64'sh7FFF_FFFF, -64'sh8000_0000,
                        52707179, -52707179,
                        HalfPiQ26, -HalfPiQ26, HalfPiQ26 - 1, HalfPiQ26 + 1,
                        -HalfPiQ26 + 1, -HalfPiQ26 - 1,
                        2 * HalfPiQ26, -2 * HalfPiQ26, 3 * HalfPiQ26, -3 * HalfPiQ26,
                        4 * HalfPiQ26, -4 * HalfPiQ26, 5 * HalfPiQ26, -5 * HalfPiQ26,
                        20 * HalfPiQ26, -20 * HalfPiQ26};

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Three phases of back-pressure: slow result side, slow request side, none.
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 22;
               recv_idle_pct = 70;
            end
            1: begin
               send_idle_pct = 70;
               recv_idle_pct = 22;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         if (phase == 0) begin
            foreach (corner_angles[n]) begin
               offer_angle(AngleWidth'(corner_angles[n]));
            end
         end
         for (int n = 0; n < PhaseItems; n++) begin
            offer_angle(pick_angle());
         end
      end
      req_tvalid <= 1'b0;

      // Drain, then allow the pipeline depth for anything unexpected to show.
      while (pending != 0) begin
         @(posedge clock);
      end
      repeat (Latency + 8) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS cordic_sine_cosine");
      end else begin
         $display("FAIL cordic_sine_cosine");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #2000000;
      $display("FAIL cordic_sine_cosine");
      $finish;
   end

endmodule
